// ----- design/left_truncatable_prime_test_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the left-truncatable prime test unit
// Clocked on clk; the plain form is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef LEFT_TRUNCATABLE_PRIME_TEST_UNIT_MACROS_SVH
`define LEFT_TRUNCATABLE_PRIME_TEST_UNIT_MACROS_SVH

// checked only outside reset
`define LTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ltp_pkg.sv -----
// ----------------------------------------------------------------------------
// ltp_pkg
// Shared widths, power-of-ten table and divider interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ltp_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int TOP_IDX    = MAX_DIGITS - 1;
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  // non-negative inputs fit in 31 bits
  localparam int N_W     = 31;
  localparam int DIV_W   = N_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // trial divisor stays below 46350, its square below 2^32
  localparam int I_W  = 17;
  localparam int SQ_W = 34;

  localparam logic [DIV_W-1:0] POW10 [0:9] = '{
    DIV_W'(1),
    DIV_W'(10),
    DIV_W'(100),
    DIV_W'(1000),
    DIV_W'(10000),
    DIV_W'(100000),
    DIV_W'(1000000),
    DIV_W'(10000000),
    DIV_W'(100000000),
    DIV_W'(1000000000)
  };

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- design/ltp_div.sv -----
// ----------------------------------------------------------------------------
// ltp_div
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ltp_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ltp_pkg::div_req_t req,
  output ltp_pkg::div_rsp_t      rsp
);

  logic                          busy;
  logic                          done;
  logic [ltp_pkg::DIV_CNT_W-1:0] count;
  logic [ltp_pkg::DIV_W-1:0]     rem;
  logic [ltp_pkg::DIV_W-1:0]     rem_next;
  logic [ltp_pkg::DIV_W-1:0]     dq;
  logic [ltp_pkg::DIV_W-1:0]     dsr;
  logic [ltp_pkg::DIV_W:0]       trial;

  always_comb begin
    trial = {rem, dq[ltp_pkg::DIV_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = ltp_pkg::DIV_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[ltp_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + ltp_pkg::DIV_CNT_W'(1);
        if (count == ltp_pkg::DIV_CNT_W'(ltp_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dq  <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[ltp_pkg::DIV_W-2:0], 1'b0};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// ----- design/left_truncatable_prime_test_unit.sv -----
// Each suffix n is tested by trial division, then its leading digit is stripped;
//   each modulo runs in the shared bit-serial remainder unit; negative and even
//   inputs finish early, without a modulo.
// Throughput: one item at a time; the next beat is taken once the result sits in
//   the output register. Reset clears control state only; no clearing pass.
// ----------------------------------------------------------------------------
// left_truncatable_prime_test_unit
// Sequencer that strips leading digits and runs 6k+-1 trial division on each
// suffix through one shared remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "left_truncatable_prime_test_unit_macros.svh"

module left_truncatable_prime_test_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      value_echo,
  output logic                    is_truncatable_prime
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRIME = 4'd1;
  localparam logic [3:0] S_MOD3  = 4'd2;
  localparam logic [3:0] S_LOOP  = 4'd3;
  localparam logic [3:0] S_MODA  = 4'd4;
  localparam logic [3:0] S_MODB  = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_DOWN  = 4'd7;
  localparam logic [3:0] S_MODD  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                  state;
  logic [3:0]                  state_next;
  logic [ltp_pkg::N_W-1:0]     n;
  logic [ltp_pkg::N_W-1:0]     n_next;
  logic [ltp_pkg::I_W-1:0]     i;
  logic [ltp_pkg::I_W-1:0]     i_next;
  logic [ltp_pkg::I_W-1:0]     i_plus2;
  logic [ltp_pkg::SQ_W-1:0]    isq;
  logic [ltp_pkg::SQ_W-1:0]    isq_next;
  logic [ltp_pkg::IDX_W-1:0]   idx;
  logic [ltp_pkg::IDX_W-1:0]   idx_next;
  logic                        verdict;
  logic                        verdict_next;
  logic signed [31:0]          item_value;
  logic                        out_load;

  ltp_pkg::div_req_t div_req;
  ltp_pkg::div_rsp_t div_rsp;

  ltp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign i_plus2  = i + ltp_pkg::I_W'(2);

  always_comb begin
    state_next       = state;
    n_next           = n;
    i_next           = i;
    isq_next         = isq;
    idx_next         = idx;
    verdict_next     = verdict;
    div_req.start    = 1'b0;
    div_req.dividend = n;
    div_req.divisor  = ltp_pkg::DIV_W'(3);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (value[31]) begin
            verdict_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            n_next     = value[ltp_pkg::N_W-1:0];
            state_next = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        if (n <= ltp_pkg::N_W'(1)) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else if (n <= ltp_pkg::N_W'(3)) begin
          state_next = S_NEXT;
        end else if (!n[0]) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_MOD3;
        end
      end
      S_MOD3: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            verdict_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            i_next     = ltp_pkg::I_W'(5);
            isq_next   = ltp_pkg::SQ_W'(25);
            state_next = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (isq > {{(ltp_pkg::SQ_W-ltp_pkg::N_W){1'b0}}, n}) begin
          state_next = S_NEXT;
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = {{(ltp_pkg::DIV_W-ltp_pkg::I_W){1'b0}}, i};
          state_next      = S_MODA;
        end
      end
      S_MODA: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            verdict_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            div_req.start   = 1'b1;
            div_req.divisor = {{(ltp_pkg::DIV_W-ltp_pkg::I_W){1'b0}}, i_plus2};
            state_next      = S_MODB;
          end
        end
      end
      S_MODB: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            verdict_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            // (i+6)^2 = i^2 + 12i + 36
            i_next     = i + ltp_pkg::I_W'(6);
            isq_next   = isq + ltp_pkg::SQ_W'({i, 3'b000}) + ltp_pkg::SQ_W'({i, 2'b00})
                         + ltp_pkg::SQ_W'(36);
            state_next = S_LOOP;
          end
        end
      end
      S_NEXT: begin
        // current suffix passed; single digit ends the walk
        if (n < ltp_pkg::N_W'(10)) begin
          verdict_next = 1'b1;
          state_next   = S_DONE;
        end else begin
          idx_next   = ltp_pkg::IDX_W'(ltp_pkg::TOP_IDX);
          state_next = S_DOWN;
        end
      end
      S_DOWN: begin
        if ((idx > ltp_pkg::IDX_W'(1)) && (n < ltp_pkg::POW10[idx])) begin
          idx_next = idx - ltp_pkg::IDX_W'(1);
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = ltp_pkg::POW10[idx];
          state_next      = S_MODD;
        end
      end
      S_MODD: begin
        if (div_rsp.done) begin
          n_next     = div_rsp.rem;
          state_next = S_PRIME;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n       <= n_next;
    i       <= i_next;
    isq     <= isq_next;
    idx     <= idx_next;
    verdict <= verdict_next;
    if (in_valid && in_ready) begin
      item_value <= value;
    end
    if (out_load) begin
      value_echo           <= item_value;
      is_truncatable_prime <= verdict;
    end
  end

  `LTP_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `LTP_ASSERT(a_neg_false, out_valid && value_echo[31] |-> !is_truncatable_prime, "negative beat reported prime")
  `LTP_ASSERT(a_even_only_two, out_valid && is_truncatable_prime && !value_echo[0] |-> value_echo == 32'sd2, "even value other than 2 reported prime")
  `LTP_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !out_valid, "output valid after reset")

endmodule

`default_nettype wire
